FILE: rtl/psq_pkg.sv
`timescale 1ns / 1ps

package psq_pkg;

  // Field widths of the request and result words
  localparam int FUNC_W = 4;
  localparam int TID_W  = 3;
  localparam int PRIO_W = 5;
  localparam int STAT_W = 2;
  localparam int RET_W  = 4;
  localparam int NEXT_W = 3;

  // Kernel request codes; codes above FN_RESCHED act as reschedule
  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE  = 4'd0,
    FN_EXIT    = 4'd1,
    FN_WAIT    = 4'd2,
    FN_SLEEP   = 4'd3,
    FN_WAKE    = 4'd4,
    FN_GETID   = 4'd5,
    FN_CHPRIO  = 4'd6,
    FN_FAULT   = 4'd7,
    FN_RESCHED = 4'd8
  } func_t;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSLOT = 2'd1;
  localparam logic [STAT_W-1:0] ST_HALT   = 2'd2;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;     // latch request word, clear result
    logic deq;         // pull running thread off its queue head
    logic enq_caller;  // requeue running thread at its tail
    logic chg_level;   // apply new priority before requeue
    logic get_id;      // return running slot
    logic retire;      // free running slot
    logic create;      // allocate and enqueue a new thread
    logic wake;        // enqueue the named thread
    logic pick;        // choose next thread, load result register
  } cmd_t;

endpackage

FILE: rtl/psq_ctrl.sv
`timescale 1ns / 1ps

module psq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [psq_pkg::FUNC_W-1:0]    in_func,
  output logic                          out_valid,
  input  logic                          out_stall,
  output psq_pkg::cmd_t                 cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEQ  = 5'b00010,
    S_OPA  = 5'b00100,
    S_OPB  = 5'b01000,
    S_PICK = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  psq_pkg::func_t  op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            pick_go;
  logic            accept;

  // Result register is free, or its word leaves this cycle
  assign pick_go  = (state_r == S_PICK) && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == S_IDLE) || pick_go);
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Fold unused codes into reschedule
  always_comb begin
    op_nxt = op_r;
    if (accept) begin
      if (in_func > psq_pkg::FN_RESCHED) begin
        op_nxt = psq_pkg::FN_RESCHED;
      end else begin
        op_nxt = psq_pkg::func_t'(in_func);
      end
    end
  end

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_DEQ;
      S_DEQ:  state_nxt = S_OPA;
      S_OPA:  state_nxt = S_OPB;
      S_OPB:  state_nxt = S_PICK;
      S_PICK: begin
        if (pick_go) begin
          state_nxt = accept ? S_DEQ : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold result valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (pick_go) out_valid_nxt = 1'b1;
  end

  // Decode commands per step
  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.pick    = pick_go;
    cmd.deq     = (state_r == S_DEQ) && (op_r != psq_pkg::FN_RESCHED);
    if (state_r == S_OPA) begin
      unique case (op_r) inside
        psq_pkg::FN_CREATE, psq_pkg::FN_WAIT, psq_pkg::FN_WAKE:
          cmd.enq_caller = 1'b1;
        psq_pkg::FN_GETID: begin
          cmd.enq_caller = 1'b1;
          cmd.get_id     = 1'b1;
        end
        psq_pkg::FN_CHPRIO: begin
          cmd.enq_caller = 1'b1;
          cmd.chg_level  = 1'b1;
        end
        psq_pkg::FN_EXIT, psq_pkg::FN_FAULT:
          cmd.retire = 1'b1;
        default: ;
      endcase
    end
    if (state_r == S_OPB) begin
      cmd.create = (op_r == psq_pkg::FN_CREATE);
      cmd.wake   = (op_r == psq_pkg::FN_WAKE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= psq_pkg::FN_RESCHED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/psq_dp.sv
`timescale 1ns / 1ps

module psq_dp #(
  parameter int THREADS = 8,
  parameter int LEVELS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  psq_pkg::cmd_t                        cmd,
  input  logic        [psq_pkg::TID_W-1:0]     in_thread_id,
  input  logic signed [psq_pkg::PRIO_W-1:0]    in_priority_req,
  output logic        [psq_pkg::STAT_W-1:0]    out_status,
  output logic        [psq_pkg::RET_W-1:0]     out_ret_value,
  output logic        [psq_pkg::NEXT_W-1:0]    out_next_thread
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Queue, link and thread tables
  logic [TW-1:0]     head_r  [LEVELS];
  logic [TW-1:0]     tail_r  [LEVELS];
  logic [LEVELS-1:0] nonempty_r;
  logic [TW-1:0]     link_r  [THREADS];
  logic [LW-1:0]     level_r [THREADS];
  logic [THREADS-1:0] ready_r;
  logic [THREADS-1:0] used_r;
  logic [TW-1:0]     run_slot_r;
  logic              run_valid_r;
  logic              halted_r;

  // Request and result registers
  logic        [psq_pkg::TID_W-1:0]  req_tid_r;
  logic signed [psq_pkg::PRIO_W-1:0] req_prio_r;
  logic        [psq_pkg::STAT_W-1:0] res_status_r;
  logic        [psq_pkg::RET_W-1:0]  res_ret_r;
  logic        [psq_pkg::STAT_W-1:0] out_status_r;
  logic        [psq_pkg::RET_W-1:0]  out_ret_r;
  logic        [psq_pkg::NEXT_W-1:0] out_next_r;

  logic [TW-1:0] cur;
  logic [LW-1:0] cur_lvl;
  logic          deq_go;
  logic [TW-1:0] deq_head;
  logic [LW-1:0] prio_clamp;
  logic [LW-1:0] new_lvl;
  logic          free_found;
  logic [TW-1:0] free_slot;
  logic [TW-1:0] tid_idx;
  logic          wake_ok;
  logic          enq_req;
  logic          enq_fresh;
  logic          enq_go;
  logic [TW-1:0] enq_slot;
  logic [LW-1:0] enq_lvl;
  logic [TW-1:0] enq_tail;
  logic          any_ready;
  logic [LW-1:0] pick_lvl;
  logic [TW-1:0] pick_head;
  logic          op_live;
  logic          caller_live;

  assign cur         = run_slot_r;
  assign cur_lvl     = level_r[cur];
  assign op_live     = !halted_r;
  assign caller_live = op_live && run_valid_r;

  // Dequeue the running thread from its queue head
  assign deq_go   = cmd.deq && caller_live && ready_r[cur];
  assign deq_head = head_r[cur_lvl];

  // Saturate requested priority into the level range
  always_comb begin
    if (req_prio_r[psq_pkg::PRIO_W-1]) begin
      prio_clamp = '0;
    end else if (int'(req_prio_r[psq_pkg::PRIO_W-2:0]) > LEVELS - 1) begin
      prio_clamp = LW'(LEVELS - 1);
    end else begin
      prio_clamp = LW'(req_prio_r[psq_pkg::PRIO_W-2:0]);
    end
  end
  assign new_lvl = req_prio_r[psq_pkg::PRIO_W-1] ? cur_lvl : prio_clamp;

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = THREADS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_slot  = TW'(i);
      end
    end
  end

  assign tid_idx = TW'(req_tid_r);
  assign wake_ok = (int'(req_tid_r) < THREADS) && used_r[tid_idx];

  // Select the one enqueue of this step
  always_comb begin
    enq_req   = 1'b0;
    enq_fresh = 1'b0;
    enq_slot  = cur;
    enq_lvl   = cur_lvl;
    if (cmd.enq_caller && caller_live) begin
      enq_req = 1'b1;
      enq_lvl = cmd.chg_level ? new_lvl : cur_lvl;
    end else if (cmd.create && op_live && free_found) begin
      enq_req   = 1'b1;
      enq_fresh = 1'b1;
      enq_slot  = free_slot;
      enq_lvl   = prio_clamp;
    end else if (cmd.wake && op_live && wake_ok) begin
      enq_req  = 1'b1;
      enq_slot = tid_idx;
      enq_lvl  = level_r[tid_idx];
    end
  end
  assign enq_go   = enq_req && (enq_fresh || !ready_r[enq_slot]);
  assign enq_tail = tail_r[enq_lvl];

  // Pick the lowest-numbered nonempty level
  assign any_ready = |nonempty_r;
  always_comb begin
    pick_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (nonempty_r[l]) pick_lvl = LW'(l);
    end
  end
  assign pick_head = head_r[pick_lvl];

  // Control state: queue flags, slot flags, levels, running thread
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r  <= '0;
      ready_r     <= '0;
      used_r      <= '0;
      run_slot_r  <= '0;
      run_valid_r <= 1'b0;
      halted_r    <= 1'b0;
      for (int t = 0; t < THREADS; t++) level_r[t] <= '0;
    end else begin
      if (deq_go) begin
        if (deq_head == tail_r[cur_lvl]) nonempty_r[cur_lvl] <= 1'b0;
        ready_r[cur] <= 1'b0;
      end
      if (cmd.retire && caller_live) begin
        used_r[cur]  <= 1'b0;
        ready_r[cur] <= 1'b0;
        level_r[cur] <= '0;
        run_valid_r  <= 1'b0;
      end
      if (cmd.chg_level && caller_live) level_r[cur] <= new_lvl;
      if (cmd.create && op_live && free_found) begin
        used_r[free_slot]  <= 1'b1;
        level_r[free_slot] <= prio_clamp;
      end
      if (enq_go) begin
        nonempty_r[enq_lvl] <= 1'b1;
        ready_r[enq_slot]   <= 1'b1;
      end
      if (cmd.pick) begin
        if (any_ready) begin
          run_slot_r  <= pick_head;
          run_valid_r <= 1'b1;
        end else begin
          halted_r    <= 1'b1;
          run_valid_r <= 1'b0;
        end
      end
    end
  end

  // Payload: queue pointers, links, request and result words
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_tid_r    <= in_thread_id;
      req_prio_r   <= in_priority_req;
      res_status_r <= psq_pkg::ST_OK;
      res_ret_r    <= '0;
    end
    if (deq_go && (deq_head != tail_r[cur_lvl])) begin
      head_r[cur_lvl] <= link_r[deq_head];
    end
    if (enq_go) begin
      if (nonempty_r[enq_lvl]) begin
        link_r[enq_tail] <= enq_slot;
      end else begin
        head_r[enq_lvl] <= enq_slot;
      end
      tail_r[enq_lvl] <= enq_slot;
    end
    if (cmd.chg_level && caller_live) res_ret_r <= (psq_pkg::RET_W)'(cur_lvl);
    if (cmd.get_id && caller_live) res_ret_r <= (psq_pkg::RET_W)'(cur);
    if (cmd.create && op_live) begin
      if (free_found) begin
        res_ret_r <= (psq_pkg::RET_W)'(free_slot);
      end else begin
        res_status_r <= psq_pkg::ST_NOSLOT;
      end
    end
    if (cmd.pick) begin
      if (any_ready) begin
        out_status_r <= res_status_r;
        out_ret_r    <= res_ret_r;
        out_next_r   <= (psq_pkg::NEXT_W)'(pick_head);
      end else begin
        out_status_r <= psq_pkg::ST_HALT;
        out_ret_r    <= '0;
        out_next_r   <= '0;
      end
    end
  end

  assign out_status      = out_status_r;
  assign out_ret_value   = out_ret_r;
  assign out_next_thread = out_next_r;

endmodule

FILE: rtl/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// Channel | Handshake           | Word
// --------+---------------------+-----------------------------------------
// in      | in_valid, in_stall  | in_func, in_thread_id, in_priority_req
// out     | out_valid, out_stall| out_status, out_ret_value, out_next_thread
//
// Each request runs through the sequencer steps: dequeue, caller
// requeue (or exit), create/wake enqueue, and priority pick.
// The next word is taken in the pick cycle, so back-to-back requests follow
// with no idle step between them while the result register drains.
// A stalled result holds the pick step, and with it the input side.
// Reset (rst_n low, synchronous) empties all queues and frees all slots.

module priority_ready_queue_scheduler #(
  parameter int THREADS = 8,
  parameter int LEVELS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [psq_pkg::FUNC_W-1:0]    in_func,
  input  logic        [psq_pkg::TID_W-1:0]     in_thread_id,
  input  logic signed [psq_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [psq_pkg::STAT_W-1:0]    out_status,
  output logic        [psq_pkg::RET_W-1:0]     out_ret_value,
  output logic        [psq_pkg::NEXT_W-1:0]    out_next_thread
);

  psq_pkg::cmd_t cmd;

  // Sequence the request steps
  psq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Hold queues and thread tables
  psq_dp #(
    .THREADS (THREADS),
    .LEVELS  (LEVELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_thread_id    (in_thread_id),
    .in_priority_req (in_priority_req),
    .out_status      (out_status),
    .out_ret_value   (out_ret_value),
    .out_next_thread (out_next_thread)
  );

endmodule

FILE: test/priority_ready_queue_scheduler_tb.sv
`timescale 1ns / 1ps

module priority_ready_queue_scheduler_tb;
  import psq_pkg::*;

  // Func codes above reschedule that the block folds into reschedule
  localparam logic [FUNC_W-1:0] FN_ALIAS_LO = 4'd9;
  localparam logic [FUNC_W-1:0] FN_ALIAS_HI = 4'd15;
  localparam int NSLOT = 8;
  localparam int NLEVEL = 16;
  localparam int PHASE_CALLS = 108;
  localparam int HOLD_LEN = 80;

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [RET_W-1:0]  rv;
    logic [NEXT_W-1:0] nx;
  } reply_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        fn;
    logic [TID_W-1:0]         tid;
    logic signed [PRIO_W-1:0] prio;
    bit                       typed;
    reply_t                   want;
  } call_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [TID_W-1:0] in_thread_id = '0;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [RET_W-1:0] out_ret_value;
  logic [NEXT_W-1:0] out_next_thread;

  // Scheduler state as the testbench tracks it
  logic [2:0] q_head [NLEVEL] = '{default: '0};
  logic [2:0] q_tail [NLEVEL] = '{default: '0};
  bit         q_busy [NLEVEL] = '{default: 1'b0};
  logic [2:0] link_nx [NSLOT] = '{default: '0};
  logic [3:0] t_level [NSLOT] = '{default: '0};
  bit         t_ready [NSLOT] = '{default: 1'b0};
  bit         t_used [NSLOT] = '{default: 1'b0};
  logic [2:0] run_slot = '0;
  bit         run_ok = 1'b0;
  bit         sched_halted = 1'b0;

  reply_t expected_replies[$];
  int fail_count = 0;
  int calls_taken = 0;
  int noslot_seen = 0;
  int halt_seen = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit pressure_on = 1'b0;
  bit pressure_done = 1'b0;

  // Directed calls; typed replies only where they follow at a glance
  call_row_t dir_rows [24] = '{
    '{FN_CREATE,   3'd0, 5'sd15,   1'b1, '{ST_OK, 4'd0, 3'd0}},
    '{FN_CREATE,   3'd0, 5'b10000, 1'b1, '{ST_OK, 4'd1, 3'd1}},  // -16 clamps to level 0
    '{FN_GETID,    3'd0, 5'sd0,    1'b1, '{ST_OK, 4'd1, 3'd1}},
    '{FN_CHPRIO,   3'd0, 5'b11111, 1'b0, '0},                   // -1 keeps the level
    '{FN_CHPRIO,   3'd0, 5'sd15,   1'b0, '0},
    '{FN_WAIT,     3'd0, 5'sd0,    1'b0, '0},
    '{FN_CREATE,   3'd0, 5'sd7,    1'b0, '0},
    '{FN_CREATE,   3'd0, 5'sd3,    1'b0, '0},
    '{FN_CREATE,   3'd0, 5'sd5,    1'b0, '0},
    '{FN_CREATE,   3'd0, 5'sd10,   1'b0, '0},
    '{FN_CREATE,   3'd0, 5'sd12,   1'b0, '0},
    '{FN_CREATE,   3'd0, 5'sd1,    1'b0, '0},
    '{FN_CREATE,   3'd0, 5'sd4,    1'b1, '{ST_NOSLOT, 4'd0, 3'd7}},
    '{FN_SLEEP,    3'd0, 5'sd0,    1'b0, '0},
    '{FN_WAKE,     3'd7, 5'sd0,    1'b0, '0},
    '{FN_WAKE,     3'd3, 5'sd0,    1'b0, '0},                   // target already ready
    '{FN_EXIT,     3'd0, 5'sd0,    1'b0, '0},
    '{FN_WAKE,     3'd7, 5'sd0,    1'b0, '0},                   // target slot is free
    '{FN_FAULT,    3'd0, 5'sd0,    1'b0, '0},
    '{FN_RESCHED,  3'd0, 5'sd0,    1'b0, '0},
    '{FN_ALIAS_HI, 3'd7, 5'b11111, 1'b0, '0},
    '{FN_ALIAS_LO, 3'd5, 5'b10000, 1'b0, '0},
    '{FN_CREATE,   3'd0, 5'sd15,   1'b0, '0},
    '{FN_GETID,    3'd0, 5'sd0,    1'b0, '0}
  };

  priority_ready_queue_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_thread_id(in_thread_id), .in_priority_req(in_priority_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_ret_value(out_ret_value), .out_next_thread(out_next_thread)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append a thread at the tail of its level unless it is already ready
  function automatic void put_ready(input logic [2:0] s);
    logic [3:0] l;
    if (t_ready[s]) return;
    l = t_level[s];
    if (q_busy[l]) link_nx[q_tail[l]] = s;
    else q_head[l] = s;
    q_tail[l] = s;
    q_busy[l] = 1'b1;
    t_ready[s] = 1'b1;
  endfunction

  // Pull the running thread off the head of its level
  function automatic void pull_running();
    logic [3:0] l;
    if (!run_ok || !t_ready[run_slot]) return;
    l = t_level[run_slot];
    if (q_head[l] == q_tail[l]) q_busy[l] = 1'b0;
    else q_head[l] = link_nx[q_head[l]];
    t_ready[run_slot] = 1'b0;
  endfunction

  // Apply one kernel call and return the reply it must produce
  function automatic reply_t kernel_call(input logic [FUNC_W-1:0] fn,
                                         input logic [TID_W-1:0] tid,
                                         input logic signed [PRIO_W-1:0] prio);
    reply_t r;
    logic [FUNC_W-1:0] fc;
    logic [2:0] cur;
    logic [2:0] slot;
    logic [3:0] lv;
    bit has;
    bit found;
    r = '0;
    cur = run_slot;
    has = run_ok;
    slot = '0;
    lv = '0;
    if (sched_halted) begin
      r.st = ST_HALT;
      return r;
    end
    fc = (fn > FN_RESCHED) ? FN_RESCHED : fn;
    if (fc != FN_RESCHED) pull_running();
    case (fc)
      FN_CREATE: begin
        found = 1'b0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
          if (!t_used[i]) begin
            found = 1'b1;
            slot = 3'(i);
          end
        end
        if (has) put_ready(cur);
        if (!found) begin
          r.st = ST_NOSLOT;
        end else begin
          t_used[slot] = 1'b1;
          t_level[slot] = (prio < 0) ? 4'd0 : prio[3:0];
          link_nx[slot] = '0;
          t_ready[slot] = 1'b0;
          put_ready(slot);
          r.rv = {1'b0, slot};
        end
      end
      FN_EXIT, FN_FAULT: begin
        if (has) begin
          t_used[cur] = 1'b0;
          t_ready[cur] = 1'b0;
          t_level[cur] = '0;
          run_ok = 1'b0;
        end
      end
      FN_WAIT: begin
        if (has) put_ready(cur);
      end
      FN_WAKE: begin
        if (has) put_ready(cur);
        if (t_used[tid]) put_ready(tid);
      end
      FN_GETID: begin
        if (has) begin
          put_ready(cur);
          r.rv = {1'b0, cur};
        end
      end
      FN_CHPRIO: begin
        if (has) begin
          r.rv = t_level[cur];
          if (prio >= 0) t_level[cur] = prio[3:0];
          put_ready(cur);
        end
      end
      default: ;
    endcase
    // Pick the head of the lowest nonempty level
    found = 1'b0;
    for (int l = NLEVEL - 1; l >= 0; l--) begin
      if (q_busy[l]) begin
        found = 1'b1;
        lv = 4'(l);
      end
    end
    if (!found) begin
      sched_halted = 1'b1;
      run_ok = 1'b0;
      r = '0;
      r.st = ST_HALT;
    end else begin
      run_slot = q_head[lv];
      run_ok = 1'b1;
      r.nx = run_slot;
    end
    return r;
  endfunction

  function automatic int ready_count();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) n += t_ready[i];
    return n;
  endfunction

  // Offer one call word, wait for it to be taken, then queue its reply
  task automatic send_call(input logic [FUNC_W-1:0] fn, input logic [TID_W-1:0] tid,
                           input logic signed [PRIO_W-1:0] prio,
                           input bit typed, input reply_t want);
    reply_t got;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_thread_id <= tid;
    in_priority_req <= prio;
    do @(posedge clk); while (in_stall);
    got = kernel_call(fn, tid, prio);
    expected_replies.push_back(typed ? want : got);
    calls_taken++;
  endtask

  // Draw a random call, biased toward wakes of sleepers; never halt early
  task automatic random_call();
    logic [FUNC_W-1:0] fn;
    logic [TID_W-1:0] tid;
    logic signed [PRIO_W-1:0] prio;
    int r;
    int start;
    r = $urandom_range(99);
    if (r < 20) fn = FN_CREATE;
    else if (r < 28) fn = FN_EXIT;
    else if (r < 40) fn = FN_WAIT;
    else if (r < 52) fn = FN_SLEEP;
    else if (r < 67) fn = FN_WAKE;
    else if (r < 75) fn = FN_GETID;
    else if (r < 87) fn = FN_CHPRIO;
    else if (r < 92) fn = FN_FAULT;
    else if (r < 97) fn = FN_RESCHED;
    else fn = 4'($urandom_range(FN_ALIAS_HI, FN_ALIAS_LO));
    if ((fn == FN_EXIT || fn == FN_SLEEP || fn == FN_FAULT) && ready_count() <= 1)
      fn = FN_CREATE;
    tid = 3'($urandom_range(NSLOT - 1));
    if (fn == FN_WAKE && $urandom_range(99) < 70) begin
      start = $urandom_range(NSLOT - 1);
      for (int k = NSLOT - 1; k >= 0; k--) begin
        if (t_used[(start + k) % NSLOT] && !t_ready[(start + k) % NSLOT])
          tid = 3'((start + k) % NSLOT);
      end
    end
    if ($urandom_range(99) < 85) prio = 5'($urandom_range(NLEVEL - 1));
    else prio = 5'($urandom_range(31));
    send_call(fn, tid, prio, 1'b0, '0);
  endtask

  // Drive stall on the reply side, with one long hold-off under pressure
  initial begin : reply_side
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (pressure_on && !pressure_done) begin
        out_stall <= 1'b1;
        held++;
        if (held == HOLD_LEN) pressure_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall);
      end
    end
  end

  // Compare each reply word taken against the oldest expectation
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: status %0d ret %0d next %0d",
               out_status, out_ret_value, out_next_thread);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.st) begin
          $error("out_status mismatch: expected %0d, got %0d", want.st, out_status);
          fail_count++;
        end
        if (out_ret_value !== want.rv) begin
          $error("out_ret_value mismatch: expected %0d, got %0d", want.rv, out_ret_value);
          fail_count++;
        end
        if (out_next_thread !== want.nx) begin
          $error("out_next_thread mismatch: expected %0d, got %0d", want.nx,
                 out_next_thread);
          fail_count++;
        end
        if (want.st == ST_NOSLOT) noslot_seen++;
        if (want.st == ST_HALT) halt_seen++;
      end
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase = '{0, 48, 0, 38};
    stall_by_phase = '{0, 0, 48, 38};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table back to back
    foreach (dir_rows[i])
      send_call(dir_rows[i].fn, dir_rows[i].tid, dir_rows[i].prio,
                dir_rows[i].typed, dir_rows[i].want);

    // Random phases; the first one also holds off the reply side for a while
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_by_phase[ph];
      recv_stall = stall_by_phase[ph];
      if (ph == 0) pressure_on = 1'b1;
      repeat (PHASE_CALLS) random_call();
    end

    // Retire threads until nothing is ready, then poke the halted block
    while (!sched_halted) send_call(FN_EXIT, 3'($urandom_range(NSLOT - 1)), '0, 1'b0, '0);
    repeat (4) send_call(4'($urandom_range(15)), 3'($urandom_range(7)),
                         5'($urandom_range(31)), 1'b0, '0);
    in_valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d kernel calls: directed table, four idle/stall mixes and a long hold-off.",
             calls_taken);
    $display("Saw %0d no-slot replies and %0d halted replies after the ready queues emptied.",
             noslot_seen, halt_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
